// File: design/cvwm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the cell voltage window mean reporter
// no dependencies

package cvwm_pkg;

    // pack geometry
    localparam int MODULES = 16;
    localparam int CELLS   = 8;
    localparam int ENTRIES = MODULES * CELLS;
    localparam int ENT_W   = $clog2(ENTRIES);

    // field widths
    localparam int MOD_W  = 4;
    localparam int CELL_W = 3;
    localparam int MV_W   = 16;
    localparam int VAL_W  = 17;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 16;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DIV_STEP_W = $clog2(MV_W);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [VAL_W-1:0] VALUE_MAX = '1;

    localparam logic [MV_W-1:0] MIN_VALID_RST = 16'd1500;
    localparam logic [MV_W-1:0] MAX_VALID_RST = 16'd4500;

    // configuration register indexes
    localparam logic CFG_MIN_VALID = 1'b0;
    localparam logic CFG_MAX_VALID = 1'b1;

    // item and report kinds
    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_CLOSE    = 1'b1;
    localparam logic REPORT_CELL   = 1'b0;
    localparam logic REPORT_MODULE = 1'b1;

    typedef logic [ENT_W-1:0] t_ent;

    typedef struct packed {
        logic              kind;
        logic [MOD_W-1:0]  module_index;
        logic [CELL_W-1:0] cell_index;
        logic              module_present;
        logic [MV_W-1:0]   cell_mv;
        logic              force_report;
    } t_in_item;

    typedef struct packed {
        logic              report_kind;
        logic [MOD_W-1:0]  out_module;
        logic [CELL_W-1:0] out_cell;
        logic [VAL_W-1:0]  value_mv;
        logic              last_report;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } t_acc;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

    function automatic t_ent entry_addr(input logic [MOD_W-1:0] m, input logic [CELL_W-1:0] c);
        return ENT_W'(int'(m) * CELLS + int'(c));
    endfunction

endpackage

// File: design/cell_voltage_window_mean_reporter.sv
`timescale 1ns / 1ps
// top level of the cell voltage window mean reporter
// depends on cvwm_pkg and cvwm_div
//
// usage
//   input channel: i_in_valid / o_in_stall carry one t_in_item per transaction,
//   either a cell sample or a window close for one module
//   output channel: o_out_valid / i_out_stall carry one t_out_item per transaction;
//   a close gives zero to nine reports, the final one flagged by last_report
//   config channel: i_cfg_valid / o_cfg_ready (always ready) write min/max valid mv
// sequencing
//   an accepted sample steps through accept, accumulator read and write back;
//   a rejected sample is dropped at accept
//   a close walks the cells one at a time: an empty cell is read and checked;
//   a cell with samples is read, checked, waits on the 16-step shared divider
//   and is evaluated, and is pushed when it reports; then comes the module
//   check, a push when the module reports, and the final flush; the input is
//   stalled for the whole close
// reset
//   control state and all valid bits clear on reset; accumulators and last
//   reported values then read as empty / never reported, no clearing pass
// output stall
//   reports sit in a one-deep output register plus a pending register; the
//   sequencer waits while both are full, no report is dropped

module cell_voltage_window_mean_reporter import cvwm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // item input
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_item,
    // report output
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_item,
    // configuration writes
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [MV_W-1:0] i_cfg_data
);

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SRD   = 10'b00_0000_0010,  // sample: read accumulator
        S_SWR   = 10'b00_0000_0100,  // sample: add and write back
        S_CRD   = 10'b00_0000_1000,  // close: read cell accumulator and last report
        S_CCHK  = 10'b00_0001_0000,  // close: empty check, start divider
        S_DIV   = 10'b00_0010_0000,  // close: wait for mean
        S_CEVAL = 10'b00_0100_0000,  // close: total and change check
        S_PUSH  = 10'b00_1000_0000,  // close: move report into pending slot
        S_MOD   = 10'b01_0000_0000,  // close: module voltage check
        S_LAST  = 10'b10_0000_0000   // close: flush final report, clear window
    } t_state;

    t_state r_state;

    // configuration
    logic [MV_W-1:0] r_min_mv;
    logic [MV_W-1:0] r_max_mv;

    // latched item
    logic [MOD_W-1:0]  r_mod;
    logic [CELL_W-1:0] r_cell;
    logic [MV_W-1:0]   r_mv;
    logic              r_force;

    // close bookkeeping
    logic [VAL_W-1:0] r_total;
    logic             r_complete;
    logic             r_after_mod;

    // report path: new report -> pending slot -> output register
    t_out_item r_new;
    t_out_item r_pend;
    logic      r_pend_vld;
    t_out_item r_out;
    logic      r_out_valid;

    // accumulator memory, an entry without its valid bit reads as empty
    t_acc r_acc_mem [ENTRIES];
    t_acc r_acc_q;
    logic [ENTRIES-1:0] r_acc_vld;

    // last cell report memory with valid bits
    logic [VAL_W-1:0] r_lc_mem [ENTRIES];
    logic [VAL_W-1:0] r_last_q;
    logic [ENTRIES-1:0] r_lc_vld;

    // last module report, small enough for flops
    logic [VAL_W-1:0]   r_lm_val [MODULES];
    logic [MODULES-1:0] r_lm_vld;

    // divider interface
    t_div_req        w_div_req;
    logic            w_div_done;
    logic [MV_W-1:0] w_div_quo;

    t_ent             w_addr;
    t_acc             w_acc_cur;
    t_acc             w_acc_wdata;
    logic             w_acc_we;
    logic             w_last_we;
    logic             w_in_acc;
    logic             w_sample_ok;
    logic             w_close_ok;
    logic             w_out_free;
    logic             w_out_load;
    t_out_item        w_out_next;
    logic             w_last_cell;
    logic             w_cell_rpt;
    logic             w_mod_rpt;
    logic [VAL_W:0]   w_total_sum;
    logic [VAL_W-1:0] w_total_next;
    logic [VAL_W-1:0] w_mean;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_sample_ok = (int'(i_in_item.module_index) < MODULES)
                      && (int'(i_in_item.cell_index) < CELLS)
                      && i_in_item.module_present
                      && (i_in_item.cell_mv >= r_min_mv)
                      && (i_in_item.cell_mv <= r_max_mv);
    assign w_close_ok  = int'(i_in_item.module_index) < MODULES;

    assign w_addr      = entry_addr(r_mod, r_cell);
    assign w_acc_cur   = r_acc_vld[w_addr] ? r_acc_q : '0;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_cell = (r_cell == CELL_W'(CELLS - 1));

    // pending report moves to the output when displaced or flushed
    assign w_out_load  = ((r_state == S_PUSH) || (r_state == S_LAST))
                      && r_pend_vld && w_out_free;

    always_comb begin
        w_out_next             = r_pend;
        w_out_next.last_report = (r_state == S_LAST);
    end

    // sample accumulation, saturated cells stay frozen
    assign w_acc_we          = (r_state == S_SWR) && (w_acc_cur.count != COUNT_MAX);
    assign w_acc_wdata.sum   = w_acc_cur.sum + SUM_W'(r_mv);
    assign w_acc_wdata.count = w_acc_cur.count + 1'b1;

    // rounded mean: (sum + count/2) / count
    assign w_div_req.start = (r_state == S_CCHK) && (w_acc_cur.count != '0);
    assign w_div_req.num   = {1'b0, w_acc_cur.sum} + NUM_W'(w_acc_cur.count >> 1);
    assign w_div_req.den   = w_acc_cur.count;

    assign w_mean       = VAL_W'(w_div_quo);
    assign w_total_sum  = {1'b0, r_total} + {1'b0, w_mean};
    assign w_total_next = w_total_sum[VAL_W] ? VALUE_MAX : w_total_sum[VAL_W-1:0];

    assign w_cell_rpt = r_force || !r_lc_vld[w_addr] || (r_last_q != w_mean);
    assign w_last_we  = (r_state == S_CEVAL) && w_cell_rpt;
    assign w_mod_rpt  = r_complete
                     && (r_force || !r_lm_vld[r_mod] || (r_lm_val[r_mod] != r_total));

    cvwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // accumulator memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_addr] <= w_acc_wdata;
        end
        r_acc_q <= r_acc_mem[w_addr];
    end

    // last cell report memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_last_we) begin
            r_lc_mem[w_addr] <= w_mean;
        end
        r_last_q <= r_lc_mem[w_addr];
    end

    // sequencer and report path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_mv    <= MIN_VALID_RST;
            r_max_mv    <= MAX_VALID_RST;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_vld   <= '0;
            r_lc_vld    <= '0;
            r_lm_vld    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_VALID: r_min_mv <= i_cfg_data;
                    CFG_MAX_VALID: r_max_mv <= i_cfg_data;
                    default:       r_min_mv <= r_min_mv;
                endcase
            end

            // output register: load the displaced or final report, else drain
            if (w_out_load) begin
                r_out       <= w_out_next;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mod       <= i_in_item.module_index;
                        r_cell      <= (i_in_item.kind == KIND_CLOSE) ? '0
                                                                      : i_in_item.cell_index;
                        r_mv        <= i_in_item.cell_mv;
                        r_force     <= i_in_item.force_report;
                        r_total     <= '0;
                        r_complete  <= 1'b1;
                        r_after_mod <= 1'b0;
                        if (i_in_item.kind == KIND_CLOSE) begin
                            if (w_close_ok) begin
                                r_state <= S_CRD;
                            end
                        end else if (w_sample_ok) begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SWR;
                end
                S_SWR: begin
                    if (w_acc_we) begin
                        r_acc_vld[w_addr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                S_CCHK: begin
                    if (w_acc_cur.count == '0) begin
                        // empty cell: no mean, module incomplete
                        r_complete <= 1'b0;
                        if (w_last_cell) begin
                            r_state <= S_MOD;
                        end else begin
                            r_cell  <= r_cell + 1'b1;
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_CEVAL;
                    end
                end
                S_CEVAL: begin
                    r_total <= w_total_next;
                    if (w_cell_rpt) begin
                        r_lc_vld[w_addr]  <= 1'b1;
                        r_new.report_kind <= REPORT_CELL;
                        r_new.out_module  <= r_mod;
                        r_new.out_cell    <= r_cell;
                        r_new.value_mv    <= w_mean;
                        r_new.last_report <= 1'b0;
                        r_state           <= S_PUSH;
                    end else if (w_last_cell) begin
                        r_state <= S_MOD;
                    end else begin
                        r_cell  <= r_cell + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_PUSH: begin
                    // the pending report is not last, since a newer one follows
                    if (!r_pend_vld || w_out_free) begin
                        r_pend     <= r_new;
                        r_pend_vld <= 1'b1;
                        if (r_after_mod) begin
                            r_state <= S_LAST;
                        end else if (w_last_cell) begin
                            r_state <= S_MOD;
                        end else begin
                            r_cell  <= r_cell + 1'b1;
                            r_state <= S_CRD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mod_rpt) begin
                        r_lm_vld[r_mod]   <= 1'b1;
                        r_lm_val[r_mod]   <= r_total;
                        r_new.report_kind <= REPORT_MODULE;
                        r_new.out_module  <= r_mod;
                        r_new.out_cell    <= '0;
                        r_new.value_mv    <= r_total;
                        r_new.last_report <= 1'b0;
                        r_after_mod       <= 1'b1;
                        r_state           <= S_PUSH;
                    end else begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (!r_pend_vld || w_out_free) begin
                        for (int c = 0; c < CELLS; c++) begin
                            r_acc_vld[entry_addr(r_mod, CELL_W'(c))] <= 1'b0;
                        end
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // divider result only arrives while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the mean wait state");

    // every close leaves the pending slot empty
    a_idle_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("pending report left behind after close");

    // a report displaced by a newer one is never flagged last
    a_push_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PUSH) && r_pend_vld && w_out_free)
        |=> (o_out_valid && !o_out_item.last_report))
        else $error("displaced report flagged as last");

    // the flush at the end of a close carries last_report
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LAST) && r_pend_vld && w_out_free)
        |=> (o_out_valid && o_out_item.last_report))
        else $error("final report of a close not flagged last");

endmodule

// File: design/cvwm_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider, one quotient bit per cycle
// depends on cvwm_pkg; assumes the quotient fits in MV_W bits

module cvwm_div import cvwm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_req        i_req,
    output logic            o_done,
    output logic [MV_W-1:0] o_quo
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_den, n_den;
    logic [MV_W-1:0]       r_quo, n_quo;

    logic [CNT_W:0] w_trial;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[MV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            // upper part is already below the divisor, so only MV_W steps remain
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = CNT_W'(i_req.num[NUM_W-1:MV_W]);
            n_quo  = i_req.num[MV_W-1:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem  = w_ge ? CNT_W'(w_trial - {1'b0, r_den}) : w_trial[CNT_W-1:0];
            n_quo  = {r_quo[MV_W-2:0], w_ge};
            n_step = r_step + 1'b1;
            if (r_step == DIV_STEP_W'(MV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
